// ===== rtl/sff_pkg.sv =====
package sff_pkg;

    localparam int MAX_TAPS   = 64;
    localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W  = 7;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int DLY_DEPTH  = 2 * MAX_TAPS;
    localparam int DLY_ADDR_W = $clog2(DLY_DEPTH);
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + TAP_IDX_W;
    localparam int GAIN_W     = 16;
    localparam int SCALED_W   = ACC_W + GAIN_W;
    localparam int SHIFT      = 31;
    localparam int TRUNC_W    = SCALED_W - SHIFT;

    localparam logic signed [GAIN_W-1:0] OUT_GAIN = 16'sd32000;

    // tuser codes on the input side
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic                         wr_dly;
        logic                         wr_coef;
        logic                         clr_acc;
        logic                         issue;
        logic [DLY_ADDR_W-1:0]        dly_addr;
        logic [TAP_IDX_W-1:0]         coef_addr;
        logic signed [SAMPLE_W-1:0]   dly_wdata;
        logic signed [COEF_W-1:0]     coef_wdata;
    } mac_ctrl_t;

endpackage

// ===== rtl/sff_mac.sv =====
module sff_mac
    import sff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mac_ctrl_t ctrl,
    output logic      busy,
    output acc_t      acc
);

    logic signed [SAMPLE_W-1:0] dly_mem  [DLY_DEPTH];
    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];

    logic [DLY_DEPTH-1:0]       dly_vld_reg;
    logic [MAX_TAPS-1:0]        coef_vld_reg;

    logic signed [SAMPLE_W-1:0] dly_q_reg;
    logic signed [COEF_W-1:0]   coef_q_reg;
    logic                       dly_ok_reg;
    logic                       coef_ok_reg;
    logic                       rd_vld_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_vld_reg;
    acc_t                       acc_reg;

    logic signed [SAMPLE_W-1:0] dly_op;
    logic signed [COEF_W-1:0]   coef_op;

    // write and read never share a cycle, so one address field serves both
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_dly)
        begin
            dly_mem[ctrl.dly_addr] <= ctrl.dly_wdata;
        end
        if (ctrl.wr_coef)
        begin
            coef_mem[ctrl.coef_addr] <= ctrl.coef_wdata;
        end
        if (ctrl.issue)
        begin
            dly_q_reg  <= dly_mem[ctrl.dly_addr];
            coef_q_reg <= coef_mem[ctrl.coef_addr];
        end
    end

    // entries never written since reset read as zero
    assign dly_op  = dly_ok_reg  ? dly_q_reg  : '0;
    assign coef_op = coef_ok_reg ? coef_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= dly_op * coef_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_vld_reg  <= '0;
            coef_vld_reg <= '0;
            dly_ok_reg   <= 1'b0;
            coef_ok_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            if (ctrl.wr_dly)
            begin
                dly_vld_reg[ctrl.dly_addr] <= 1'b1;
            end
            if (ctrl.wr_coef)
            begin
                coef_vld_reg[ctrl.coef_addr] <= 1'b1;
            end
            if (ctrl.issue)
            begin
                dly_ok_reg  <= dly_vld_reg[ctrl.dly_addr];
                coef_ok_reg <= coef_vld_reg[ctrl.coef_addr];
            end
            rd_vld_reg   <= ctrl.issue;
            prod_vld_reg <= rd_vld_reg;
            if (ctrl.clr_acc)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
    end

    assign busy = rd_vld_reg | prod_vld_reg;
    assign acc  = acc_reg;

endmodule

// ===== rtl/stereo_fir_filter_unit.sv =====
// Channel    Dir  Fields (low bit up)
// s_axis     in   tdata: sample_in[15:0] coef_index[21:16] coef_value[39:22]
//                 tuser: command   tlast: end_of_block
// m_axis     out  tdata: sample_out[15:0]  tuser: channel_out  tlast: last_out
// tap_count  in   write enable + 7-bit data, written at any edge with enable
//
// From acceptance to result, a sample makes one read of the delay and
// coefficient memories per tap, then multiply, accumulate, scale and saturate.
// A coefficient load gives no result.
// Reset clears the memory valid bits at once; no clearing pass is needed.
// A result waiting on m_tready does not block acceptance of the next item;
// only the following result then waits for the output register.
module stereo_fir_filter_unit
    import sff_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // sample_in, coef_index, coef_value
    input  logic                 s_tuser,   // command
    input  logic                 s_tlast,   // end_of_block

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // sample_out
    output logic                 m_tuser,   // channel_out
    output logic                 m_tlast,   // last_out

    input  logic                 tap_count_wr_en,
    input  logic [TAP_CNT_W-1:0] tap_count_wr_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAC   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [TAP_CNT_W-1:0]       tap_count_reg;
    logic [TAP_IDX_W-1:0]       wpos_reg [2];
    logic                       toggle_reg;
    logic                       ch_reg;
    logic                       last_reg;
    logic [TAP_IDX_W-1:0]       pos_reg;
    logic [TAP_IDX_W-1:0]       k_reg, k_next;
    logic [TAP_IDX_W-1:0]       taps_m1_reg;
    logic signed [SCALED_W-1:0] scaled_reg;

    logic                       out_vld_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic                       out_ch_reg;
    logic                       out_last_reg;

    logic                       in_acc;
    logic                       acc_sample;
    logic                       acc_load;
    logic                       out_load;
    logic [TAP_CNT_W-1:0]       taps_clamped;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [TAP_IDX_W-1:0]       coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    mac_ctrl_t                  mac_ctrl;
    logic                       mac_busy;
    acc_t                       mac_acc;

    logic signed [SCALED_W-1:0] scaled_next;
    logic signed [SCALED_W-1:0] biased;
    logic signed [TRUNC_W-1:0]  trunc_q;
    logic signed [SAMPLE_W-1:0] sat_q;

    assign sample_in  = s_tdata[15:0];
    assign coef_index = s_tdata[21:16];
    assign coef_value = s_tdata[39:22];

    assign s_tready   = (state_reg == S_IDLE);
    assign in_acc     = s_tvalid & s_tready;
    assign acc_sample = in_acc & (s_tuser == CMD_SAMPLE);
    assign acc_load   = in_acc & (s_tuser == CMD_LOAD);
    assign out_load   = (state_reg == S_DONE) & (~out_vld_reg | m_tready);

    always_comb
    begin
        taps_clamped = tap_count_reg;
        priority if (tap_count_reg == '0)
        begin
            taps_clamped = TAP_CNT_W'(1);
        end
        else if (tap_count_reg > TAP_CNT_W'(MAX_TAPS))
        begin
            taps_clamped = TAP_CNT_W'(MAX_TAPS);
        end
    end

    always_comb
    begin
        mac_ctrl            = '0;
        mac_ctrl.dly_wdata  = sample_in;
        mac_ctrl.coef_wdata = coef_value;
        mac_ctrl.wr_dly     = acc_sample;
        mac_ctrl.wr_coef    = acc_load;
        mac_ctrl.clr_acc    = acc_sample;
        if (state_reg == S_MAC)
        begin
            mac_ctrl.issue     = 1'b1;
            mac_ctrl.dly_addr  = {ch_reg, pos_reg - k_reg};
            mac_ctrl.coef_addr = k_reg;
        end
        else
        begin
            mac_ctrl.dly_addr  = {toggle_reg, wpos_reg[toggle_reg]};
            mac_ctrl.coef_addr = coef_index;
        end
    end

    sff_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_sample)
                begin
                    state_next = S_MAC;
                    k_next     = '0;
                end
            end
            S_MAC:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == taps_m1_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // truncate toward zero: bias negatives by 2^31-1 before the arithmetic shift
    assign scaled_next = mac_acc * OUT_GAIN;
    assign biased      = scaled_reg + (scaled_reg[SCALED_W-1] ?
                         SCALED_W'((64'd1 << SHIFT) - 64'd1) : SCALED_W'(0));
    assign trunc_q     = biased[SCALED_W-1:SHIFT];

    always_comb
    begin
        priority if (trunc_q > TRUNC_W'(32767))
        begin
            sat_q = 16'sh7FFF;
        end
        else if (trunc_q < -TRUNC_W'(32768))
        begin
            sat_q = 16'sh8000;
        end
        else
        begin
            sat_q = trunc_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_sample)
        begin
            ch_reg      <= toggle_reg;
            pos_reg     <= wpos_reg[toggle_reg];
            last_reg    <= s_tlast;
            taps_m1_reg <= TAP_IDX_W'(taps_clamped - 1'b1);
        end
        if (state_reg == S_SCALE)
        begin
            scaled_reg <= scaled_next;
        end
        if (out_load)
        begin
            out_data_reg <= sat_q;
            out_ch_reg   <= ch_reg;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            tap_count_reg <= TAP_CNT_W'(1);
            wpos_reg[0]   <= '0;
            wpos_reg[1]   <= '0;
            toggle_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (tap_count_wr_en)
            begin
                tap_count_reg <= tap_count_wr_data;
            end
            if (acc_sample)
            begin
                wpos_reg[toggle_reg] <= wpos_reg[toggle_reg] + 1'b1;
                toggle_reg           <= ~toggle_reg;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;

    a_sample_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        acc_sample |=> state_reg == S_MAC)
        else $error("sample accepted without starting the tap loop");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc_load |=> state_reg == S_IDLE && !$rose(m_tvalid))
        else $error("coefficient load produced work or a result");

    a_acc_settled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCALE |-> !mac_busy)
        else $error("scaling started before the accumulator settled");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the done state");

endmodule
